FILE: rtl/query_string_decoder_splitter_defines.svh
// assertion macros shared by the rtl
`ifndef QUERY_STRING_DECODER_SPLITTER_DEFINES_SVH
`define QUERY_STRING_DECODER_SPLITTER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define QSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/qsd_pkg.sv
package qsd_pkg;

   // length limit, positions stop here
   localparam longint unsigned MAX_LENGTH = 65535;
   localparam logic [15:0] POS_LIMIT =
      (MAX_LENGTH < 64'd65535) ? MAX_LENGTH[15:0] : 16'hFFFF;

   // default depth of the queue between front and back
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // result kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_ARG  = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // operations handed from front to back
   localparam logic [1:0] OP_DATA = 2'd0;
   localparam logic [1:0] OP_EQ   = 2'd1;
   localparam logic [1:0] OP_AMP  = 2'd2;
   localparam logic [1:0] OP_END  = 2'd3;

   // characters of interest
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_SPACE = 8'h20;

   typedef struct packed {
      logic [7:0] raw_byte;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  decoded_byte;
      logic [15:0] name_offset;
      logic [15:0] name_size;
      logic [15:0] value_offset;
      logic [15:0] value_size;
      logic [15:0] decoded_length;
      logic        too_long;
      logic        final_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] code;
      logic [7:0] data;
      logic       ends_run;
   } op_type;

endpackage

FILE: rtl/qsd_front.sv
module qsd_front import qsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    op_valid,
   input  logic    op_ready,
   output op_type  op_data
);

   typedef struct packed {
      op_type     op;
      logic [1:0] used;
   } head_type;

   logic [7:0] buf_ff [3];
   logic [7:0] buf_in [3];
   logic [1:0] cnt_ff, cnt_in;
   logic       flush_ff, flush_in;
   logic       accept;
   head_type   head_norm, head_flush;

   // bit 4 flags a valid hex digit
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // classify the head of a window of n raw bytes
   function automatic head_type decode_head(input logic [7:0] b0, input logic [7:0] b1,
                                            input logic [7:0] b2, input logic [1:0] n);
      head_type   h;
      logic [4:0] d0;
      logic [4:0] d1;
      d0 = hex_nibble(b1);
      d1 = hex_nibble(b2);
      h.op.code     = OP_DATA;
      h.op.data     = b0;
      h.op.ends_run = 1'b0;
      h.used        = 2'd1;
      case (b0)
         CH_EQ: begin
            h.op.code = OP_EQ;
         end
         CH_AMP: begin
            h.op.code = OP_AMP;
         end
         CH_PLUS: begin
            h.op.data = CH_SPACE;
         end
         CH_PCT: begin
            if (n == 2'd3 && d0[4] && d1[4]) begin
               h.op.data = {d0[3:0], d1[3:0]};
               h.used    = 2'd3;
            end
         end
         default: begin
         end
      endcase
      return h;
   endfunction

   assign head_norm  = decode_head(buf_ff[0], buf_ff[1], req_payload.raw_byte, 2'd3);
   assign head_flush = decode_head(buf_ff[0], buf_ff[1], buf_ff[2], cnt_ff);

   // no new request while the tail of a string drains
   assign req_ready = !flush_ff && op_ready;
   assign accept    = req_valid && req_ready;

   // lookahead window and flush sequencing
   always_comb begin
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      flush_in = flush_ff;
      op_valid = 1'b0;
      op_data  = head_norm.op;
      if (flush_ff) begin
         op_valid = 1'b1;
         if (cnt_ff == 2'd0) begin
            op_data.code     = OP_END;
            op_data.data     = 8'd0;
            op_data.ends_run = 1'b1;
            if (op_ready) begin
               flush_in = 1'b0;
            end
         end else begin
            op_data = head_flush.op;
            if (op_ready) begin
               if (head_flush.used == 2'd3) begin
                  cnt_in = 2'd0;
               end else begin
                  buf_in[0] = buf_ff[1];
                  buf_in[1] = buf_ff[2];
                  cnt_in    = cnt_ff - 2'd1;
               end
            end
         end
      end else if (accept) begin
         if (req_payload.is_last) begin
            buf_in[cnt_ff] = req_payload.raw_byte;
            cnt_in         = cnt_ff + 2'd1;
            flush_in       = 1'b1;
         end else if (cnt_ff == 2'd2) begin
            op_valid         = 1'b1;
            op_data.ends_run = 1'b1;
            if (head_norm.used == 2'd3) begin
               cnt_in = 2'd0;
            end else begin
               buf_in[0] = buf_ff[1];
               buf_in[1] = req_payload.raw_byte;
            end
         end else begin
            buf_in[cnt_ff] = req_payload.raw_byte;
            cnt_in         = cnt_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= 2'd0;
         flush_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         flush_ff <= flush_in;
      end
      buf_ff <= buf_in;
   end

endmodule

FILE: rtl/qsd_fifo.sv
module qsd_fifo import qsd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   in_valid,
   output logic   in_ready,
   input  op_type in_data,
   output logic   out_valid,
   input  logic   out_ready,
   output op_type out_data
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   op_type           mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = cnt_ff != CNT_W'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer wrap and occupancy
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff + CNT_W'(push) - CNT_W'(pop);
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_data;
      end
   end

endmodule

FILE: rtl/qsd_back.sv
module qsd_back import qsd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   output logic    op_ready,
   input  op_type  op_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic [15:0] pos_ff, pos_in, piece_ff, piece_in;
   logic [15:0] name_start_ff, name_start_in, held_ff, held_in;
   logic        seen_ff, seen_in, ovf_ff, ovf_in;
   logic        phase_ff, phase_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in, rec_ff, rec_in;

   logic        out_free;
   logic        pos_room;
   logic [15:0] pos_step, piece_len;
   logic        piece_live;
   rsp_type     piece_rec, byte_rsp, end_rsp;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // saturating position advance for one emitted byte
   assign pos_room = pos_ff < POS_LIMIT;
   assign pos_step = pos_room ? pos_ff + 16'd1 : pos_ff;

   // record of the current piece, closed at the current position
   assign piece_len  = (pos_ff >= piece_ff) ? pos_ff - piece_ff : 16'd0;
   assign piece_live = (seen_ff && held_ff != 16'd0) || pos_ff != piece_ff;

   always_comb begin
      piece_rec      = '0;
      piece_rec.kind = KIND_ARG;
      if (seen_ff) begin
         piece_rec.name_offset  = name_start_ff;
         piece_rec.name_size    = held_ff;
         piece_rec.value_offset = piece_ff;
         piece_rec.value_size   = piece_len;
      end else begin
         piece_rec.name_offset  = piece_ff;
         piece_rec.name_size    = piece_len;
         piece_rec.value_offset = piece_ff;
      end
      byte_rsp              = '0;
      byte_rsp.kind         = KIND_BYTE;
      byte_rsp.decoded_byte = op_data.data;
      byte_rsp.final_of_run = op_data.ends_run;
      end_rsp                = '0;
      end_rsp.kind           = KIND_END;
      end_rsp.decoded_length = pos_ff;
      end_rsp.too_long       = ovf_ff;
      end_rsp.final_of_run   = op_data.ends_run;
   end

   // execute the head operation, one result per cycle while the output is free
   always_comb begin
      op_ready      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      rec_in        = rec_ff;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      piece_in      = piece_ff;
      name_start_in = name_start_ff;
      held_in       = held_ff;
      seen_in       = seen_ff;
      ovf_in        = ovf_ff;
      if (op_valid && out_free) begin
         rsp_valid_in = 1'b1;
         case (op_data.code)
            OP_EQ: begin
               rsp_in   = byte_rsp;
               op_ready = 1'b1;
               pos_in   = pos_step;
               ovf_in   = ovf_ff || !pos_room;
               if (!seen_ff) begin
                  name_start_in = piece_ff;
                  held_in       = pos_ff - piece_ff;
                  seen_in       = 1'b1;
                  piece_in      = pos_step;
               end
            end
            OP_AMP: begin
               if (!phase_ff) begin
                  rsp_in              = byte_rsp;
                  rsp_in.final_of_run = op_data.ends_run && !piece_live;
                  rec_in              = piece_rec;
                  pos_in              = pos_step;
                  ovf_in              = ovf_ff || !pos_room;
                  seen_in             = 1'b0;
                  held_in             = 16'd0;
                  name_start_in       = 16'd0;
                  piece_in            = pos_step;
                  if (piece_live) begin
                     phase_in = 1'b1;
                  end else begin
                     op_ready = 1'b1;
                  end
               end else begin
                  rsp_in              = rec_ff;
                  rsp_in.final_of_run = op_data.ends_run;
                  phase_in            = 1'b0;
                  op_ready            = 1'b1;
               end
            end
            OP_END: begin
               if (!phase_ff && piece_live) begin
                  rsp_in   = piece_rec;
                  phase_in = 1'b1;
               end else begin
                  rsp_in        = end_rsp;
                  phase_in      = 1'b0;
                  op_ready      = 1'b1;
                  pos_in        = 16'd0;
                  piece_in      = 16'd0;
                  name_start_in = 16'd0;
                  held_in       = 16'd0;
                  seen_in       = 1'b0;
                  ovf_in        = 1'b0;
               end
            end
            default: begin
               rsp_in   = byte_rsp;
               op_ready = 1'b1;
               pos_in   = pos_step;
               ovf_in   = ovf_ff || !pos_room;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         phase_ff      <= 1'b0;
         pos_ff        <= 16'd0;
         piece_ff      <= 16'd0;
         name_start_ff <= 16'd0;
         held_ff       <= 16'd0;
         seen_ff       <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         piece_ff      <= piece_in;
         name_start_ff <= name_start_in;
         held_ff       <= held_in;
         seen_ff       <= seen_in;
         ovf_ff        <= ovf_in;
      end
      rsp_ff <= rsp_in;
      rec_ff <= rec_in;
   end

endmodule

FILE: rtl/query_string_decoder_splitter.sv
// URL query string decoder: takes one raw byte per clock and returns the percent-decoded
// byte stream ('+' as space, %XY as one byte, '=' and '&' passed through), an argument
// record after each '&' that closes a non-empty piece, and after the byte flagged is_last
// the record of the last piece and an end record with the decoded length and an overflow
// flag. A byte is decoded once two more bytes have arrived; the front holds that lookahead
// and turns each byte or %XY triple into one operation, which a small queue hands to the
// back, where the positions are kept and one result leaves per clock, when rsp_ready
// allows, through a registered output. Input runs at one byte per clock while req_ready
// is high. Each '&' that closes a piece is followed by its record. After the last byte
// the front drains its lookahead, one operation per clock while the queue has room, and
// takes no request meanwhile; the back then delivers the rest at the same rate.
`include "query_string_decoder_splitter_defines.svh"

module query_string_decoder_splitter import qsd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic   push_valid, push_ready;
   op_type push_data;
   logic   pop_valid, pop_ready;
   op_type pop_data;
   logic   push_stall, last_taken, end_shown;

   // lookahead and classification
   qsd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .op_valid    (push_valid),
      .op_ready    (push_ready),
      .op_data     (push_data)
   );

   // operation queue
   qsd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // position tracking and result generation
   qsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (pop_valid),
      .op_ready    (pop_ready),
      .op_data     (pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // terms for the checks
   assign push_stall = push_valid && !push_ready;
   assign last_taken = req_valid && req_ready && req_payload.is_last;
   assign end_shown  = rsp_valid && rsp_payload.kind == KIND_END;

   // checks
   `QSD_ASSERT_NEXT(a_push_hold, clock, reset, push_stall, $stable(push_data), "push changed")
   `QSD_ASSERT_NEXT(a_last_stops_intake, clock, reset, last_taken, !req_ready, "drain intake")
   `QSD_ASSERT_NOW(a_end_final, clock, reset, end_shown, rsp_payload.final_of_run, "end early")

endmodule
